// ----- src/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg: ARP cache responder shared types
// Word formats, slot kinds, result codes and register indexes used by the
// cache cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [1:0]  OP_REPLY    = 2'd2;

    localparam logic [MAC_W-1:0] HOST_MAC_DEFAULT = {6{8'haa}};

    typedef enum logic [1:0] {
        KIND_FREE    = 2'd0,
        KIND_DYNAMIC = 2'd1,
        KIND_STATIC  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_REPLY       = 3'd0,
        ST_BAD_HW      = 3'd1,
        ST_BAD_PROTO   = 3'd2,
        ST_NOT_FOR_US  = 3'd3,
        ST_NOT_REQUEST = 3'd4,
        ST_HIT         = 3'd5,
        ST_MISS        = 3'd6
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OWN_IP   = 2'd0,
        CFG_OWN_MAC  = 2'd1,
        CFG_HOST_IP  = 2'd2,
        CFG_HOST_MAC = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_LEARN  = 2'd1,
        MODE_LOOKUP = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_HOLD = 2'd2
    } fsm_t;

    // probe word handed from cell to cell
    typedef struct packed {
        logic             valid;
        mode_t            mode;
        logic             done;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } probe_t;

    typedef struct packed {
        logic             func;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [15:0]      arp_op;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  wanted_ip;
        logic [IP_W-1:0]  query_ip;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [1:0]       reply_op;
        logic [MAC_W-1:0] reply_src_mac;
        logic [IP_W-1:0]  reply_src_ip;
        logic [MAC_W-1:0] reply_dst_mac;
        logic [IP_W-1:0]  reply_dst_ip;
        logic [MAC_W-1:0] found_mac;
    } out_item_t;

endpackage

`default_nettype wire

// ----- src/arp_cache_responder.sv -----
// ----------------------------------------------------------------------------
// arp_cache_responder: ARP cache with request responder
// Learns senders of received ARP packets, answers requests for our IP and
// resolves lookups, by sending a probe word down a row of slot cells.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, in_word               | in
//  result   | out_valid, out_ready, out_word            | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  One item at a time: the probe word crosses one slot cell per cycle down
//  the row, and its result is caught in a pending register on exit.
//  in_ready returns once the result has moved into the output register, so
//  the next item may enter while that result still waits on out_ready.
//  Reset puts every slot free except the last, which holds the host entry.
//  cfg_ready is always high; host writes reload the last slot at once.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_responder #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire arpc_pkg::in_item_t                in_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output arpc_pkg::out_item_t                    out_word,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [arpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [arpc_pkg::IP_W-1:0]  own_ip_reg, host_ip_reg;
    logic [arpc_pkg::MAC_W-1:0] own_mac_reg, host_mac_reg;

    arpc_pkg::fsm_t      state_reg, state_next;
    arpc_pkg::probe_t    launch_reg, launch_next;
    logic                func_reg;
    arpc_pkg::status_t   pkt_status_reg, pkt_status_next;
    logic [arpc_pkg::IP_W-1:0]  src_ip_reg;
    logic [arpc_pkg::MAC_W-1:0] src_mac_reg;
    arpc_pkg::out_item_t pend_reg, pend_next;
    arpc_pkg::out_item_t out_reg;
    logic                out_valid_reg, out_valid_next;

    arpc_pkg::probe_t    link [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0] chain_vld;

    logic in_accept;
    logic cfg_write;
    logic move_out;
    logic host_load;
    logic [arpc_pkg::IP_W-1:0]  host_ip_load;
    logic [arpc_pkg::MAC_W-1:0] host_mac_load;
    arpc_pkg::cfg_index_t cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_sel   = arpc_pkg::cfg_index_t'(cfg_index);
    assign in_accept = in_valid && in_ready;
    assign move_out  = (state_reg == arpc_pkg::FSM_HOLD) && (!out_valid_reg || out_ready);

    // ---- configuration ----
    assign host_load = cfg_write &&
                       (cfg_sel == arpc_pkg::CFG_HOST_IP || cfg_sel == arpc_pkg::CFG_HOST_MAC);
    assign host_ip_load  = (cfg_sel == arpc_pkg::CFG_HOST_IP) ?
                           cfg_data[arpc_pkg::IP_W-1:0] : host_ip_reg;
    assign host_mac_load = (cfg_sel == arpc_pkg::CFG_HOST_MAC) ? cfg_data : host_mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg   <= '0;
            own_mac_reg  <= '0;
            host_ip_reg  <= '0;
            host_mac_reg <= arpc_pkg::HOST_MAC_DEFAULT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                arpc_pkg::CFG_OWN_IP:   own_ip_reg   <= cfg_data[arpc_pkg::IP_W-1:0];
                arpc_pkg::CFG_OWN_MAC:  own_mac_reg  <= cfg_data;
                arpc_pkg::CFG_HOST_IP:  host_ip_reg  <= cfg_data[arpc_pkg::IP_W-1:0];
                arpc_pkg::CFG_HOST_MAC: host_mac_reg <= cfg_data;
                default:                own_ip_reg   <= own_ip_reg;
            endcase
        end
    end

    // ---- state machine ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arpc_pkg::FSM_IDLE: if (in_accept)      state_next = arpc_pkg::FSM_SCAN;
            arpc_pkg::FSM_SCAN: if (link[TABLE_ENTRIES].valid)
                                                    state_next = arpc_pkg::FSM_HOLD;
            arpc_pkg::FSM_HOLD: if (move_out)       state_next = arpc_pkg::FSM_IDLE;
            default:                                state_next = arpc_pkg::FSM_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == arpc_pkg::FSM_IDLE);
    end

    // ---- item launch ----
    always_comb
    begin
        launch_next       = '0;
        launch_next.valid = in_accept;
        launch_next.done  = 1'b0;
        launch_next.mac   = in_word.sender_mac;
        if (in_word.func)
        begin
            launch_next.mode = arpc_pkg::MODE_LOOKUP;
            launch_next.ip   = in_word.query_ip;
        end
        else
        begin
            launch_next.ip   = in_word.sender_ip;
            launch_next.mode = (in_word.hw_type == arpc_pkg::HW_ETHERNET &&
                                in_word.proto_type == arpc_pkg::PROTO_IPV4) ?
                               arpc_pkg::MODE_LEARN : arpc_pkg::MODE_NONE;
        end
    end

    always_comb
    begin
        priority if (in_word.hw_type != arpc_pkg::HW_ETHERNET)
            pkt_status_next = arpc_pkg::ST_BAD_HW;
        else if (in_word.proto_type != arpc_pkg::PROTO_IPV4)
            pkt_status_next = arpc_pkg::ST_BAD_PROTO;
        else if (in_word.wanted_ip != own_ip_reg)
            pkt_status_next = arpc_pkg::ST_NOT_FOR_US;
        else if (in_word.arp_op != arpc_pkg::OP_REQUEST)
            pkt_status_next = arpc_pkg::ST_NOT_REQUEST;
        else
            pkt_status_next = arpc_pkg::ST_REPLY;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg       <= in_word.func;
            pkt_status_reg <= pkt_status_next;
            src_ip_reg     <= in_word.sender_ip;
            src_mac_reg    <= in_word.sender_mac;
        end
    end

    // ---- row of slot cells ----
    assign link[0] = launch_reg;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_slot
        if (g == TABLE_ENTRIES - 1)
        begin : g_host
            arpc_cell #(.IS_HOST(1'b1)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .probe_in  (link[g]),
                .probe_out (link[g+1]),
                .load_en   (host_load),
                .load_ip   (host_ip_load),
                .load_mac  (host_mac_load)
            );
        end
        else
        begin : g_plain
            arpc_cell #(.IS_HOST(1'b0)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .probe_in  (link[g]),
                .probe_out (link[g+1]),
                .load_en   (1'b0),
                .load_ip   ('0),
                .load_mac  ('0)
            );
        end
    end

    for (genvar v = 0; v <= TABLE_ENTRIES; v++)
    begin : g_vld
        assign chain_vld[v] = link[v].valid;
    end

    // ---- result ----
    always_comb
    begin
        pend_next = '0;
        if (func_reg)
        begin
            if (link[TABLE_ENTRIES].done)
            begin
                pend_next.status    = arpc_pkg::ST_HIT;
                pend_next.found_mac = link[TABLE_ENTRIES].mac;
            end
            else
                pend_next.status = arpc_pkg::ST_MISS;
        end
        else
        begin
            pend_next.status = pkt_status_reg;
            if (pkt_status_reg == arpc_pkg::ST_REPLY)
            begin
                pend_next.reply_op      = arpc_pkg::OP_REPLY;
                pend_next.reply_src_mac = own_mac_reg;
                pend_next.reply_src_ip  = own_ip_reg;
                pend_next.reply_dst_mac = src_mac_reg;
                pend_next.reply_dst_ip  = src_ip_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (link[TABLE_ENTRIES].valid)
            pend_reg <= pend_next;
        if (move_out)
            out_reg <= pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arpc_pkg::FSM_IDLE;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // ---- checks ----
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_vld))
        else $error("more than one probe word in the slot row");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arpc_pkg::FSM_IDLE) |-> (chain_vld == '0))
        else $error("probe word in flight while idle");

    a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        link[TABLE_ENTRIES].valid |-> (state_reg == arpc_pkg::FSM_SCAN))
        else $error("probe word left the row outside a scan");

    a_hold_fill: assert property (@(posedge clk) disable iff (!rst_n)
        move_out |=> out_valid_reg && (state_reg == arpc_pkg::FSM_IDLE))
        else $error("result not presented after move to output");

endmodule

`default_nettype wire

// ----- src/arpc_cell.sv -----
// ----------------------------------------------------------------------------
// arpc_cell: one ARP table slot
// Holds one entry and handles the probe word passing by, then hands the
// word on to the next slot in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell #(
    parameter bit IS_HOST = 1'b0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire arpc_pkg::probe_t            probe_in,
    output arpc_pkg::probe_t                 probe_out,
    input  wire logic                        load_en,
    input  wire logic [arpc_pkg::IP_W-1:0]   load_ip,
    input  wire logic [arpc_pkg::MAC_W-1:0]  load_mac
);

    logic [arpc_pkg::IP_W-1:0]  ip_reg, ip_next;
    logic [arpc_pkg::MAC_W-1:0] mac_reg, mac_next;
    arpc_pkg::kind_t            kind_reg, kind_next;
    arpc_pkg::probe_t           probe_reg, probe_next;

    logic is_free;
    logic is_hit;

    assign is_free = (kind_reg == arpc_pkg::KIND_FREE);
    assign is_hit  = !is_free && (ip_reg == probe_in.ip);

    always_comb
    begin
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        kind_next  = kind_reg;
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.done)
        begin
            unique case (probe_in.mode)
                arpc_pkg::MODE_LEARN:
                begin
                    if (is_free)
                    begin
                        ip_next         = probe_in.ip;
                        mac_next        = probe_in.mac;
                        kind_next       = arpc_pkg::KIND_DYNAMIC;
                        probe_next.done = 1'b1;
                    end
                    else if (is_hit)
                    begin
                        // static entries keep their MAC
                        if (kind_reg == arpc_pkg::KIND_DYNAMIC)
                            mac_next = probe_in.mac;
                        probe_next.done = 1'b1;
                    end
                end
                arpc_pkg::MODE_LOOKUP:
                begin
                    if (is_hit)
                    begin
                        probe_next.done = 1'b1;
                        probe_next.mac  = mac_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (load_en)
        begin
            ip_next   = load_ip;
            mac_next  = load_mac;
            kind_next = arpc_pkg::KIND_STATIC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg    <= '0;
            mac_reg   <= IS_HOST ? arpc_pkg::HOST_MAC_DEFAULT : '0;
            kind_reg  <= IS_HOST ? arpc_pkg::KIND_STATIC : arpc_pkg::KIND_FREE;
            probe_reg <= '0;
        end
        else
        begin
            ip_reg    <= ip_next;
            mac_reg   <= mac_next;
            kind_reg  <= kind_next;
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

// ----- tb/arp_cache_checker.sv -----
// ----------------------------------------------------------------------------
// arp_cache_checker: result predictor and scoreboard for arp_cache_responder
// Watches the input, result and register write channels. Keeps its own copy
// of the cache table and registers, works out the result word of every
// accepted input word, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module arp_cache_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  arpc_pkg::in_item_t               in_word,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  arpc_pkg::out_item_t              out_word,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [arpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               outstanding,
    output int                               mismatches
);

    logic [arpc_pkg::IP_W-1:0]  own_ip_q;
    logic [arpc_pkg::MAC_W-1:0] own_mac_q;
    logic [arpc_pkg::IP_W-1:0]  host_ip_q;
    logic [arpc_pkg::MAC_W-1:0] host_mac_q;

    logic [arpc_pkg::IP_W-1:0]  cache_ip   [TABLE_ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] cache_mac  [TABLE_ENTRIES];
    arpc_pkg::kind_t            cache_kind [TABLE_ENTRIES];

    arpc_pkg::out_item_t awaited_results[$];
    int                  results_seen;

    task automatic load_host_entry();
        cache_ip[TABLE_ENTRIES-1]   = host_ip_q;
        cache_mac[TABLE_ENTRIES-1]  = host_mac_q;
        cache_kind[TABLE_ENTRIES-1] = arpc_pkg::KIND_STATIC;
    endtask

    // first free slot takes the sender; a used slot with the same IP stops the scan
    task automatic learn_sender(input logic [arpc_pkg::IP_W-1:0] ip,
                                input logic [arpc_pkg::MAC_W-1:0] mac);
        bit stop;
        stop = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!stop) begin
                if (cache_kind[i] == arpc_pkg::KIND_FREE) begin
                    cache_ip[i]   = ip;
                    cache_mac[i]  = mac;
                    cache_kind[i] = arpc_pkg::KIND_DYNAMIC;
                    stop = 1'b1;
                end else if (cache_ip[i] == ip) begin
                    if (cache_kind[i] == arpc_pkg::KIND_DYNAMIC)
                        cache_mac[i] = mac;
                    stop = 1'b1;
                end
            end
        end
    endtask

    task automatic resolve_word(input arpc_pkg::in_item_t w, output arpc_pkg::out_item_t r);
        bit hit;
        r   = '0;
        hit = 1'b0;
        if (w.func) begin
            r.status = arpc_pkg::ST_MISS;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!hit && cache_kind[i] != arpc_pkg::KIND_FREE &&
                    cache_ip[i] == w.query_ip) begin
                    hit         = 1'b1;
                    r.status    = arpc_pkg::ST_HIT;
                    r.found_mac = cache_mac[i];
                end
            end
        end else if (w.hw_type != arpc_pkg::HW_ETHERNET) begin
            r.status = arpc_pkg::ST_BAD_HW;
        end else if (w.proto_type != arpc_pkg::PROTO_IPV4) begin
            r.status = arpc_pkg::ST_BAD_PROTO;
        end else begin
            learn_sender(w.sender_ip, w.sender_mac);
            if (w.wanted_ip != own_ip_q) begin
                r.status = arpc_pkg::ST_NOT_FOR_US;
            end else if (w.arp_op != arpc_pkg::OP_REQUEST) begin
                r.status = arpc_pkg::ST_NOT_REQUEST;
            end else begin
                r.status        = arpc_pkg::ST_REPLY;
                r.reply_op      = arpc_pkg::OP_REPLY;
                r.reply_src_mac = own_mac_q;
                r.reply_src_ip  = own_ip_q;
                r.reply_dst_mac = w.sender_mac;
                r.reply_dst_ip  = w.sender_ip;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h actual %h",
                         results_seen, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        arpc_pkg::out_item_t want;
        arpc_pkg::out_item_t fresh;
        if (!rst_n) begin
            own_ip_q   = '0;
            own_mac_q  = '0;
            host_ip_q  = '0;
            host_mac_q = arpc_pkg::HOST_MAC_DEFAULT;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                cache_ip[i]   = '0;
                cache_mac[i]  = '0;
                cache_kind[i] = arpc_pkg::KIND_FREE;
            end
            load_host_entry();
            awaited_results.delete();
            results_seen = 0;
            mismatches   = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    arpc_pkg::CFG_OWN_IP:   own_ip_q  = cfg_data[arpc_pkg::IP_W-1:0];
                    arpc_pkg::CFG_OWN_MAC:  own_mac_q = cfg_data[arpc_pkg::MAC_W-1:0];
                    arpc_pkg::CFG_HOST_IP:
                    begin
                        host_ip_q = cfg_data[arpc_pkg::IP_W-1:0];
                        load_host_entry();
                    end
                    arpc_pkg::CFG_HOST_MAC:
                    begin
                        host_mac_q = cfg_data[arpc_pkg::MAC_W-1:0];
                        load_host_entry();
                    end
                    default: ;
                endcase
            end
            // retire the oldest result before queueing a new one
            if (out_valid && out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing awaited: %h",
                                 results_seen, out_word);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 64'(want.status), 64'(out_word.status));
                    check_field("reply_op", 64'(want.reply_op), 64'(out_word.reply_op));
                    check_field("reply_src_mac", 64'(want.reply_src_mac),
                                64'(out_word.reply_src_mac));
                    check_field("reply_src_ip", 64'(want.reply_src_ip),
                                64'(out_word.reply_src_ip));
                    check_field("reply_dst_mac", 64'(want.reply_dst_mac),
                                64'(out_word.reply_dst_mac));
                    check_field("reply_dst_ip", 64'(want.reply_dst_ip),
                                64'(out_word.reply_dst_ip));
                    check_field("found_mac", 64'(want.found_mac), 64'(out_word.found_mac));
                end
            end
            if (in_valid && in_ready) begin
                resolve_word(in_word, fresh);
                awaited_results.push_back(fresh);
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ----- tb/arp_cache_responder_tb.sv -----
// ----------------------------------------------------------------------------
// arp_cache_responder_tb: stimulus and verdict for arp_cache_responder
// Directed ARP packets and lookups cover drops, replies, refreshes, the
// static host entry and a full table; random phases under several register
// settings follow, with random gaps, a long result stall and idle-only drains.
// ----------------------------------------------------------------------------
module arp_cache_responder_tb;

    localparam int TABLE_ENTRIES = 16;
    localparam int POOL_SIZE     = 20;
    localparam int PHASE_ITEMS   = 275;
    localparam int LONG_HOLD     = 300;
    localparam int LIMIT_CYCLES  = 400_000;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    arpc_pkg::in_item_t               in_word;
    logic                             out_valid;
    logic                             out_ready;
    arpc_pkg::out_item_t              out_word;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [arpc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data;

    int outstanding;
    int mismatches;
    int cycle_count;

    bit                        calm;
    bit                        hold_req;
    logic [arpc_pkg::IP_W-1:0] cur_own_ip;
    logic [arpc_pkg::IP_W-1:0] ip_pool [POOL_SIZE];

    arp_cache_responder #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    arp_cache_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .outstanding(outstanding),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[arpc_pkg::MAC_W-1:0];
    endfunction

    function automatic logic [arpc_pkg::IP_W-1:0] pick_ip();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic arpc_pkg::in_item_t make_packet(input logic [15:0] hw,
                                                       input logic [15:0] proto,
                                                       input logic [15:0] op,
                                                       input logic [arpc_pkg::IP_W-1:0] sip,
                                                       input logic [arpc_pkg::MAC_W-1:0] smac,
                                                       input logic [arpc_pkg::IP_W-1:0] tip);
        arpc_pkg::in_item_t w;
        w.func       = 1'b0;
        w.hw_type    = hw;
        w.proto_type = proto;
        w.arp_op     = op;
        w.sender_ip  = sip;
        w.sender_mac = smac;
        w.wanted_ip  = tip;
        w.query_ip   = $urandom();
        return w;
    endfunction

    // packet fields ride along as junk on a lookup word
    function automatic arpc_pkg::in_item_t make_lookup(input logic [arpc_pkg::IP_W-1:0] ip);
        arpc_pkg::in_item_t w;
        w = make_packet(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(),
                        rand_mac(), $urandom());
        w.func     = 1'b1;
        w.query_ip = ip;
        return w;
    endfunction

    function automatic arpc_pkg::in_item_t random_item();
        int                 pick;
        int                 op_pick;
        logic [15:0]        op;
        arpc_pkg::in_item_t w;
        pick    = $urandom_range(0, 99);
        op_pick = $urandom_range(0, 9);
        op = (op_pick < 7) ? arpc_pkg::OP_REQUEST :
             (op_pick < 9) ? 16'(arpc_pkg::OP_REPLY) : 16'($urandom());
        if (pick < 40)
            w = make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, op, pick_ip(),
                            rand_mac(),
                            ($urandom_range(0, 9) < 6) ? cur_own_ip : pick_ip());
        else if (pick < 75)
            w = make_lookup(pick_ip());
        else
            w = make_packet($urandom_range(0, 1) ? arpc_pkg::HW_ETHERNET : 16'($urandom()),
                            $urandom_range(0, 1) ? arpc_pkg::PROTO_IPV4 : 16'($urandom()),
                            16'($urandom()), pick_ip(), rand_mac(), pick_ip());
        return w;
    endfunction

    task automatic send_item(input arpc_pkg::in_item_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // outstanding is registered in the checker, hence the first wait
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input arpc_pkg::cfg_index_t idx,
                             input logic [arpc_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [arpc_pkg::IP_W-1:0] own_ip,
                             input logic [arpc_pkg::MAC_W-1:0] own_mac,
                             input logic [arpc_pkg::IP_W-1:0] host_ip,
                             input logic [arpc_pkg::MAC_W-1:0] host_mac);
        write_reg(arpc_pkg::CFG_OWN_IP, arpc_pkg::CFG_DATA_W'(own_ip));
        write_reg(arpc_pkg::CFG_OWN_MAC, own_mac);
        write_reg(arpc_pkg::CFG_HOST_IP, arpc_pkg::CFG_DATA_W'(host_ip));
        write_reg(arpc_pkg::CFG_HOST_MAC, host_mac);
        cfg_valid  <= 1'b0;
        cur_own_ip = own_ip;
    endtask

    task automatic run_phase(input int count);
        repeat (count) send_item(random_item());
        drain();
    endtask

    // result side: random stall per word, or one long hold when asked
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req <= 1'b0;
                stall = LONG_HOLD;
            end
            else
            begin
                stall = calm ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("arp_cache_responder verification failed");
        $finish;
    end

    initial
    begin
        logic [arpc_pkg::IP_W-1:0]  own_ip;
        logic [arpc_pkg::MAC_W-1:0] own_mac;
        logic [arpc_pkg::IP_W-1:0]  host_ip;
        logic [arpc_pkg::MAC_W-1:0] host_mac;
        logic [arpc_pkg::MAC_W-1:0] smac;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        cur_own_ip = '0;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: host entry at IP zero with the default MAC
        send_item(make_lookup('0));
        send_item(make_lookup(ip_pool[3]));
        drain();

        own_ip   = 32'hc0a8_0001;
        own_mac  = 48'h0200_0000_0001;
        host_ip  = 32'hc0a8_00fe;
        host_mac = 48'h0200_0000_00fe;
        configure(own_ip, own_mac, host_ip, host_mac);

        send_item(make_lookup('0));
        send_item(make_lookup(host_ip));
        send_item(make_packet(16'h0000, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                              32'hc0a8_0010, rand_mac(), own_ip));
        send_item(make_packet(16'hffff, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                              32'hc0a8_0010, rand_mac(), own_ip));
        send_item(make_packet(arpc_pkg::HW_ETHERNET, 16'h0000, arpc_pkg::OP_REQUEST,
                              32'hc0a8_0010, rand_mac(), own_ip));
        send_item(make_packet(arpc_pkg::HW_ETHERNET, 16'hffff, arpc_pkg::OP_REQUEST,
                              32'hc0a8_0010, rand_mac(), own_ip));
        send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                              arpc_pkg::OP_REQUEST, 32'hc0a8_0010,
                              48'h0200_0000_0010, own_ip));
        // same sender again refreshes its dynamic entry
        send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                              16'(arpc_pkg::OP_REPLY), 32'hc0a8_0010,
                              48'h0200_0000_0011, own_ip));
        send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'hffff,
                              32'hc0a8_0020, rand_mac(), own_ip));
        send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'h0000,
                              32'hc0a8_0020, rand_mac(), own_ip));
        send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                              arpc_pkg::OP_REQUEST, 32'hc0a8_0030, rand_mac(),
                              32'hc0a8_0002));
        // sender on the static host entry: entry must stay as it is
        send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                              arpc_pkg::OP_REQUEST, host_ip, rand_mac(), own_ip));
        send_item(make_lookup(host_ip));
        send_item(make_lookup(32'hc0a8_0010));
        // fill the table, the last senders find no slot
        for (int k = 0; k < 15; k++)
        begin
            smac = (k == 0) ? '0 : (k == 1) ? '1 : rand_mac();
            send_item(make_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                  arpc_pkg::OP_REQUEST, 32'h0a00_0000 + 32'(k),
                                  smac, $urandom()));
        end
        send_item(make_lookup(32'h0a00_000e));
        send_item(make_lookup(32'h0a00_0000));
        drain();

        // host write reloads the static entry
        configure(own_ip, own_mac, 32'hc0a8_00fd, 48'h0200_0000_00fd);
        send_item(make_lookup(32'hc0a8_00fd));
        send_item(make_lookup(host_ip));
        drain();

        configure('1, '1, ip_pool[2], '1);
        run_phase(PHASE_ITEMS);

        configure('0, '0, '0, '0);
        run_phase(PHASE_ITEMS);

        // long result stall: the block fills and holds off the input
        configure(ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac(),
                  ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac());
        hold_req <= 1'b1;
        run_phase(PHASE_ITEMS);

        // back-to-back words with no idling on either side
        configure(ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac(),
                  ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac());
        calm = 1'b1;
        run_phase(PHASE_ITEMS);
        calm = 1'b0;

        configure(ip_pool[$urandom_range(0, POOL_SIZE - 1)], rand_mac(), $urandom(),
                  rand_mac());
        run_phase(PHASE_ITEMS);

        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("arp_cache_responder verification clean");
        else
            $display("arp_cache_responder verification failed");
        $finish;
    end

endmodule
